@@ design/gn3_pkg.sv @@
`timescale 1ns / 1ps

package gn3_pkg;

    // Table and number format
    localparam int TABLE_SIZE = 256;                   // power of two
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 24;
    localparam int OUT_W      = 18;                    // Q2.16 result
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int VAL_W      = (IDX_W > 8) ? IDX_W : 8;
    localparam int ONE        = 1 << FRAC_BITS;

    // Datapath widths
    localparam int FADE_W = FRAC_BITS + 1;             // 0..ONE
    localparam int OFS_W  = FRAC_BITS + 2;             // t or t-1, signed
    localparam int GRAD_W = FRAC_BITS + 3;             // sum of two offsets
    localparam int DIFF_W = FRAC_BITS + 4;
    localparam int ACC_W  = FRAC_BITS + 6;             // blended values
    localparam int P_W    = FRAC_BITS + 6;             // fade polynomial
    localparam int RS_W   = 2 * FRAC_BITS + 8;         // products

    localparam int CORNERS    = 8;
    localparam int PIPE_DEPTH = 11;

    // Conversion of the Q.F result to Q2.16
    localparam int CONV_DN = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int CONV_UP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic signed [RS_W-1:0] SAT_HI = RS_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [RS_W-1:0] SAT_LO = RS_W'(-(1 << (OUT_W - 1)));

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_EVAL = 1'b1
    } req_kind_t;

    typedef struct packed {
        req_kind_t          req_type;
        logic [7:0]         table_index;
        logic [7:0]         table_value;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
    } req_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] noise_value;
    } res_t;

    // Permutation write travelling down the hash stages
    typedef struct packed {
        logic             wr;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
    } load_t;

    typedef logic [CORNERS-1:0][3:0] hash_vec_t;

    // Right shift by s, rounding half away from zero
    function automatic logic signed [RS_W-1:0] round_shift(
        input logic signed [RS_W-1:0] v,
        input int unsigned            s
    );
        logic signed [RS_W-1:0] half;
        logic signed [RS_W-1:0] m;
        if (s == 0)
        begin
            return v;
        end
        half = RS_W'(1) <<< (s - 1);
        if (v >= 0)
        begin
            return (v + half) >>> s;
        end
        m = -v;
        m = (m + half) >>> s;
        return -m;
    endfunction

    // Standard twelve-gradient pick from the low four hash bits
    function automatic logic signed [GRAD_W-1:0] grad_dot(
        input logic [3:0]              h,
        input logic signed [OFS_W-1:0] x,
        input logic signed [OFS_W-1:0] y,
        input logic signed [OFS_W-1:0] z
    );
        logic signed [GRAD_W-1:0] a;
        logic signed [GRAD_W-1:0] b;
        a = (h < 4'd8) ? GRAD_W'(x) : GRAD_W'(y);
        if (h < 4'd4)
        begin
            b = GRAD_W'(y);
        end
        else if (h == 4'd12 || h == 4'd14)
        begin
            b = GRAD_W'(x);
        end
        else
        begin
            b = GRAD_W'(z);
        end
        if (h[0])
        begin
            a = -a;
        end
        if (h[1])
        begin
            b = -b;
        end
        return a + b;
    endfunction

endpackage

@@ design/gn3_req_if.sv @@
`timescale 1ns / 1ps

interface gn3_req_if
    import gn3_pkg::*;
    ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/gn3_res_if.sv @@
`timescale 1ns / 1ps

interface gn3_res_if
    import gn3_pkg::*;
    ();
    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/gn3_perm_bank.sv @@
`timescale 1ns / 1ps

// One copy of the permutation table: one write port, two registered reads.
// Entries never written read as their own index.
module gn3_perm_bank
    import gn3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             we,
    input  logic [IDX_W-1:0] wa,
    input  logic [VAL_W-1:0] wd,
    input  logic [IDX_W-1:0] ra0,
    input  logic [IDX_W-1:0] ra1,
    output logic [VAL_W-1:0] rd0,
    output logic [VAL_W-1:0] rd1
);

    logic [VAL_W-1:0]      mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] written_reg;
    logic [VAL_W-1:0]      mem0_reg;
    logic [VAL_W-1:0]      mem1_reg;
    logic                  hit0_reg;
    logic                  hit1_reg;
    logic [IDX_W-1:0]      addr0_reg;
    logic [IDX_W-1:0]      addr1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (we)
        begin
            written_reg[wa] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (en)
        begin
            mem0_reg  <= mem[ra0];
            mem1_reg  <= mem[ra1];
            hit0_reg  <= written_reg[ra0];
            hit1_reg  <= written_reg[ra1];
            addr0_reg <= ra0;
            addr1_reg <= ra1;
        end
    end

    assign rd0 = hit0_reg ? mem0_reg : VAL_W'(addr0_reg);
    assign rd1 = hit1_reg ? mem1_reg : VAL_W'(addr1_reg);

endmodule

@@ design/gn3_hash.sv @@
`timescale 1ns / 1ps

// Three hash levels, stages 1..3. Each level has its own table copies; a load
// writes a level's copies when it passes that level, keeping item order.
module gn3_hash
    import gn3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  load_t            ld,
    input  logic [IDX_W-1:0] cx,
    input  logic [IDX_W-1:0] cy,
    input  logic [IDX_W-1:0] cz,
    output hash_vec_t        hash
);

    load_t            ld1_reg;
    load_t            ld2_reg;
    logic [IDX_W-1:0] y1_reg;
    logic [IDX_W-1:0] z1_reg;
    logic [IDX_W-1:0] z2_reg;

    logic [VAL_W-1:0] p_x;
    logic [VAL_W-1:0] p_x1;
    logic [VAL_W-1:0] p_a;
    logic [VAL_W-1:0] p_a1;
    logic [VAL_W-1:0] p_b;
    logic [VAL_W-1:0] p_b1;
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;
    logic [IDX_W-1:0] aa_idx;
    logic [IDX_W-1:0] ab_idx;
    logic [IDX_W-1:0] ba_idx;
    logic [IDX_W-1:0] bb_idx;
    logic [VAL_W-1:0] h_rd [CORNERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld1_reg <= '0;
            ld2_reg <= '0;
        end
        else if (en)
        begin
            ld1_reg <= ld;
            ld2_reg <= ld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y1_reg <= cy;
            z1_reg <= cz;
            z2_reg <= z1_reg;
        end
    end

    // Level 1: P[X], P[X+1]
    gn3_perm_bank u_lvl1 (
        .clk, .rst_n, .en,
        .we(en & ld.wr), .wa(ld.idx), .wd(ld.val),
        .ra0(cx), .ra1(cx + IDX_W'(1)),
        .rd0(p_x), .rd1(p_x1)
    );

    // Low bits of the sums give the wrapped index
    assign a_idx = IDX_W'(p_x + VAL_W'(y1_reg));
    assign b_idx = IDX_W'(p_x1 + VAL_W'(y1_reg));

    // Level 2: P[A], P[A+1], P[B], P[B+1]
    gn3_perm_bank u_lvl2a (
        .clk, .rst_n, .en,
        .we(en & ld1_reg.wr), .wa(ld1_reg.idx), .wd(ld1_reg.val),
        .ra0(a_idx), .ra1(a_idx + IDX_W'(1)),
        .rd0(p_a), .rd1(p_a1)
    );

    gn3_perm_bank u_lvl2b (
        .clk, .rst_n, .en,
        .we(en & ld1_reg.wr), .wa(ld1_reg.idx), .wd(ld1_reg.val),
        .ra0(b_idx), .ra1(b_idx + IDX_W'(1)),
        .rd0(p_b), .rd1(p_b1)
    );

    assign aa_idx = IDX_W'(p_a + VAL_W'(z2_reg));
    assign ab_idx = IDX_W'(p_a1 + VAL_W'(z2_reg));
    assign ba_idx = IDX_W'(p_b + VAL_W'(z2_reg));
    assign bb_idx = IDX_W'(p_b1 + VAL_W'(z2_reg));

    // Level 3: corner hashes; corner bit 0 = x+1, bit 1 = y+1, bit 2 = z+1
    gn3_perm_bank u_lvl3aa (
        .clk, .rst_n, .en,
        .we(en & ld2_reg.wr), .wa(ld2_reg.idx), .wd(ld2_reg.val),
        .ra0(aa_idx), .ra1(aa_idx + IDX_W'(1)),
        .rd0(h_rd[0]), .rd1(h_rd[4])
    );

    gn3_perm_bank u_lvl3ba (
        .clk, .rst_n, .en,
        .we(en & ld2_reg.wr), .wa(ld2_reg.idx), .wd(ld2_reg.val),
        .ra0(ba_idx), .ra1(ba_idx + IDX_W'(1)),
        .rd0(h_rd[1]), .rd1(h_rd[5])
    );

    gn3_perm_bank u_lvl3ab (
        .clk, .rst_n, .en,
        .we(en & ld2_reg.wr), .wa(ld2_reg.idx), .wd(ld2_reg.val),
        .ra0(ab_idx), .ra1(ab_idx + IDX_W'(1)),
        .rd0(h_rd[2]), .rd1(h_rd[6])
    );

    gn3_perm_bank u_lvl3bb (
        .clk, .rst_n, .en,
        .we(en & ld2_reg.wr), .wa(ld2_reg.idx), .wd(ld2_reg.val),
        .ra0(bb_idx), .ra1(bb_idx + IDX_W'(1)),
        .rd0(h_rd[3]), .rd1(h_rd[7])
    );

    always_comb
    begin
        for (int i = 0; i < CORNERS; i++)
        begin
            hash[i] = h_rd[i][3:0];
        end
    end

endmodule

@@ design/gn3_fade.sv @@
`timescale 1ns / 1ps

// Quintic fade 6t^5-15t^4+10t^3 by Horner's rule, one multiply in each of stages 1..4.
// Input at stage 0, output registered at stage 5.
module gn3_fade
    import gn3_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [FRAC_BITS-1:0] t,
    output logic [FADE_W-1:0]    f
);

    logic signed [P_W-1:0]    p0;
    logic signed [P_W-1:0]    p1;
    logic signed [P_W-1:0]    p2;
    logic signed [P_W-1:0]    p3;
    logic signed [RS_W-1:0]   p4;
    logic signed [FADE_W:0]   t0_s;
    logic signed [FADE_W:0]   t1_s;
    logic signed [FADE_W:0]   t2_s;
    logic signed [FADE_W:0]   t3_s;
    logic [FRAC_BITS-1:0]     t1_reg;
    logic [FRAC_BITS-1:0]     t2_reg;
    logic [FRAC_BITS-1:0]     t3_reg;
    logic signed [RS_W-1:0]   prod1_reg;
    logic signed [RS_W-1:0]   prod2_reg;
    logic signed [RS_W-1:0]   prod3_reg;
    logic signed [RS_W-1:0]   prod4_reg;
    logic [FADE_W-1:0]        f_reg;
    logic [FADE_W-1:0]        f_next;

    assign t0_s = (FADE_W + 1)'(t);
    assign t1_s = (FADE_W + 1)'(t1_reg);
    assign t2_s = (FADE_W + 1)'(t2_reg);
    assign t3_s = (FADE_W + 1)'(t3_reg);

    assign p0 = P_W'(6 * int'(t) - 15 * ONE);
    assign p1 = P_W'(round_shift(prod1_reg, FRAC_BITS) + RS_W'(10 * ONE));
    assign p2 = P_W'(round_shift(prod2_reg, FRAC_BITS));
    assign p3 = P_W'(round_shift(prod3_reg, FRAC_BITS));
    assign p4 = round_shift(prod4_reg, FRAC_BITS);

    always_comb
    begin
        if (p4 < 0)
        begin
            f_next = '0;
        end
        else if (p4 > RS_W'(ONE))
        begin
            f_next = FADE_W'(ONE);
        end
        else
        begin
            f_next = FADE_W'(p4);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= p0 * t0_s;
            t1_reg    <= t;
            prod2_reg <= p1 * t1_s;
            t2_reg    <= t1_reg;
            prod3_reg <= p2 * t2_s;
            t3_reg    <= t2_reg;
            prod4_reg <= p3 * t3_s;
            f_reg     <= f_next;
        end
    end

    assign f = f_reg;

endmodule

@@ design/gn3_mix.sv @@
`timescale 1ns / 1ps

// Corner gradients (stage 4) and the trilinear blend tree (stages 5..11).
module gn3_mix
    import gn3_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  hash_vec_t               hash,
    input  logic [FRAC_BITS-1:0]    fx,
    input  logic [FRAC_BITS-1:0]    fy,
    input  logic [FRAC_BITS-1:0]    fz,
    input  logic [FADE_W-1:0]       u,
    input  logic [FADE_W-1:0]       v,
    input  logic [FADE_W-1:0]       w,
    output logic signed [OUT_W-1:0] r
);

    logic signed [OFS_W-1:0]  ox [2];
    logic signed [OFS_W-1:0]  oy [2];
    logic signed [OFS_W-1:0]  oz [2];
    logic signed [GRAD_W-1:0] g_reg  [CORNERS];
    logic signed [GRAD_W-1:0] ga_reg [4];
    logic signed [DIFF_W-1:0] gd_reg [4];
    logic signed [GRAD_W-1:0] la_reg [4];
    logic signed [RS_W-1:0]   pu_reg [4];
    logic signed [ACC_W-1:0]  l_reg  [4];
    logic signed [ACC_W-1:0]  lb_reg [2];
    logic signed [RS_W-1:0]   pv_reg [2];
    logic signed [ACC_W-1:0]  m_reg  [2];
    logic signed [ACC_W-1:0]  m0_reg;
    logic signed [RS_W-1:0]   pw_reg;
    logic [FADE_W-1:0]        v6_reg;
    logic [FADE_W-1:0]        v7_reg;
    logic [FADE_W-1:0]        w6_reg;
    logic [FADE_W-1:0]        w7_reg;
    logic [FADE_W-1:0]        w8_reg;
    logic [FADE_W-1:0]        w9_reg;
    logic signed [FADE_W:0]   u_s;
    logic signed [FADE_W:0]   v_s;
    logic signed [FADE_W:0]   w_s;
    logic signed [ACC_W:0]    dv [2];
    logic signed [ACC_W:0]    dw;
    logic signed [RS_W-1:0]   r_sum;
    logic signed [RS_W-1:0]   r_conv;
    logic signed [OUT_W-1:0]  r_next;
    logic signed [OUT_W-1:0]  r_reg;

    // Corner offsets t and t-1
    assign ox[0] = OFS_W'(fx);
    assign oy[0] = OFS_W'(fy);
    assign oz[0] = OFS_W'(fz);
    assign ox[1] = ox[0] - OFS_W'(ONE);
    assign oy[1] = oy[0] - OFS_W'(ONE);
    assign oz[1] = oz[0] - OFS_W'(ONE);

    assign u_s = (FADE_W + 1)'(u);
    assign v_s = (FADE_W + 1)'(v7_reg);
    assign w_s = (FADE_W + 1)'(w9_reg);

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            dv[j] = (ACC_W + 1)'(l_reg[2*j+1]) - (ACC_W + 1)'(l_reg[2*j]);
        end
        dw     = (ACC_W + 1)'(m_reg[1]) - (ACC_W + 1)'(m_reg[0]);
        r_sum  = RS_W'(m0_reg) + round_shift(pw_reg, FRAC_BITS);
        r_conv = round_shift(r_sum, CONV_DN) <<< CONV_UP;
        if (r_conv > SAT_HI)
        begin
            r_next = OUT_W'(SAT_HI);
        end
        else if (r_conv < SAT_LO)
        begin
            r_next = OUT_W'(SAT_LO);
        end
        else
        begin
            r_next = OUT_W'(r_conv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 4
            for (int i = 0; i < CORNERS; i++)
            begin
                g_reg[i] <= grad_dot(hash[i], ox[i % 2], oy[(i / 2) % 2], oz[i / 4]);
            end
            // stage 5: pairs along x
            for (int k = 0; k < 4; k++)
            begin
                ga_reg[k] <= g_reg[2*k];
                gd_reg[k] <= DIFF_W'(g_reg[2*k+1]) - DIFF_W'(g_reg[2*k]);
            end
            // stage 6
            for (int k = 0; k < 4; k++)
            begin
                pu_reg[k] <= u_s * gd_reg[k];
                la_reg[k] <= ga_reg[k];
            end
            v6_reg <= v;
            w6_reg <= w;
            // stage 7
            for (int k = 0; k < 4; k++)
            begin
                l_reg[k] <= ACC_W'(RS_W'(la_reg[k]) + round_shift(pu_reg[k], FRAC_BITS));
            end
            v7_reg <= v6_reg;
            w7_reg <= w6_reg;
            // stage 8: pairs along y
            for (int j = 0; j < 2; j++)
            begin
                pv_reg[j] <= v_s * dv[j];
                lb_reg[j] <= l_reg[2*j];
            end
            w8_reg <= w7_reg;
            // stage 9
            for (int j = 0; j < 2; j++)
            begin
                m_reg[j] <= ACC_W'(RS_W'(lb_reg[j]) + round_shift(pv_reg[j], FRAC_BITS));
            end
            w9_reg <= w8_reg;
            // stage 10: along z
            pw_reg <= w_s * dw;
            m0_reg <= m_reg[0];
            // stage 11
            r_reg  <= r_next;
        end
    end

    assign r = r_reg;

endmodule

@@ design/gradient_noise_3d_unit.sv @@
`timescale 1ns / 1ps

// Improved 3-D gradient noise, one point per clock. An evaluate transfer
// carries x, y, z as unsigned 8.16 fixed point; the result (signed Q2.16,
// saturated) leaves the final stage, and the unit accepts a new transfer
// every cycle as long as the output side keeps taking results. A load
// transfer writes one permutation entry and yields no result; it occupies
// one input slot like any other transfer. The table comes out of reset as
// the identity and is usable at once, with no clearing pass. Loads and
// evaluations may be freely interleaved: each evaluation sees exactly the
// loads that were transferred before it. Throughput is one item per cycle,
// set by the 11-stage pipeline (three table-lookup levels, four fade
// multiplies, three blend levels); the whole pipeline holds while a finished
// result waits at the output.
module gradient_noise_3d_unit
    import gn3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gn3_req_if.sink   req,
    gn3_res_if.source res
);

    logic                  en;
    logic                  accept;
    logic [PIPE_DEPTH:1]   vld_reg;
    logic [PIPE_DEPTH:1]   vld_next;
    load_t                 ld;
    logic [IDX_W-1:0]      cx;
    logic [IDX_W-1:0]      cy;
    logic [IDX_W-1:0]      cz;
    logic [FRAC_BITS-1:0]  fx_reg [1:3];
    logic [FRAC_BITS-1:0]  fy_reg [1:3];
    logic [FRAC_BITS-1:0]  fz_reg [1:3];
    hash_vec_t             hash;
    logic [FADE_W-1:0]     fade_u;
    logic [FADE_W-1:0]     fade_v;
    logic [FADE_W-1:0]     fade_w;
    logic signed [OUT_W-1:0] noise;

    // Whole pipeline advances unless the output holds an untaken result
    assign en        = !vld_reg[PIPE_DEPTH] || res.ready;
    assign req.ready = en;
    assign accept    = req.valid && en;

    // Loads past the end of the table are dropped
    assign ld.wr  = accept && (req.data.req_type == REQ_LOAD) &&
                    (int'(req.data.table_index) < TABLE_SIZE);
    assign ld.idx = IDX_W'(req.data.table_index);
    assign ld.val = VAL_W'(req.data.table_value);

    // Integer parts wrap modulo the table size
    assign cx = IDX_W'(req.data.coord_x >> FRAC_BITS);
    assign cy = IDX_W'(req.data.coord_y >> FRAC_BITS);
    assign cz = IDX_W'(req.data.coord_z >> FRAC_BITS);

    always_comb
    begin
        vld_next    = vld_reg;
        if (en)
        begin
            vld_next    = vld_reg << 1;
            vld_next[1] = accept && (req.data.req_type == REQ_EVAL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Fractions ride along until the gradient stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx_reg[1] <= req.data.coord_x[FRAC_BITS-1:0];
            fy_reg[1] <= req.data.coord_y[FRAC_BITS-1:0];
            fz_reg[1] <= req.data.coord_z[FRAC_BITS-1:0];
            for (int s = 2; s <= 3; s++)
            begin
                fx_reg[s] <= fx_reg[s-1];
                fy_reg[s] <= fy_reg[s-1];
                fz_reg[s] <= fz_reg[s-1];
            end
        end
    end

    gn3_hash u_hash (
        .clk, .rst_n, .en, .ld, .cx, .cy, .cz, .hash
    );

    gn3_fade u_fade_x (
        .clk, .en, .t(req.data.coord_x[FRAC_BITS-1:0]), .f(fade_u)
    );

    gn3_fade u_fade_y (
        .clk, .en, .t(req.data.coord_y[FRAC_BITS-1:0]), .f(fade_v)
    );

    gn3_fade u_fade_z (
        .clk, .en, .t(req.data.coord_z[FRAC_BITS-1:0]), .f(fade_w)
    );

    gn3_mix u_mix (
        .clk, .en, .hash,
        .fx(fx_reg[3]), .fy(fy_reg[3]), .fz(fz_reg[3]),
        .u(fade_u), .v(fade_v), .w(fade_w),
        .r(noise)
    );

    assign res.valid            = vld_reg[PIPE_DEPTH];
    assign res.data.noise_value = noise;

`ifndef SYNTHESIS
    // A result only appears after an item left the stage before the output
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(vld_reg[PIPE_DEPTH-1]))
        else $error("result without an item in the last stage");

    // A held pipeline keeps every slot
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline slots changed during a stall");

    // A load never starts an evaluation
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.data.req_type == REQ_LOAD) |=> !vld_reg[1])
        else $error("load transfer entered the evaluation pipeline");

    // Fade weights stay within zero to one
    a_fade_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] |-> (fade_u <= ONE && fade_v <= ONE && fade_w <= ONE))
        else $error("fade weight out of range");
`endif

endmodule
